/* rtl/core/tcl_pkg.sv */
// Package for the timed cue lookup: opcode, register map, reset values,
// controller state type and index type. No dependencies.
`default_nettype none

package tcl_pkg;

  localparam int OUT_IDX_W = 10;
  typedef logic [OUT_IDX_W-1:0] cue_idx_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_CUE_COUNT   = 2'd0;
  localparam logic [1:0] REG_BACK_WINDOW = 2'd1;
  localparam logic [1:0] REG_FWD_WINDOW  = 2'd2;

  localparam logic [10:0] CUE_COUNT_RST   = 11'd0;
  localparam logic [15:0] BACK_WINDOW_RST = 16'd2000;
  localparam logic [15:0] FWD_WINDOW_RST  = 16'd5000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMPTY,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_FIN_RD,
    ST_FIN_CHK,
    ST_WALK_RD_DN,
    ST_WALK_DN,
    ST_WALK_RD_UP,
    ST_WALK_UP
  } tcl_state_t;

endpackage

`default_nettype wire

/* rtl/core/timed_cue_lookup.sv */
// Timed cue lookup: a load word writes one cue into the table. A query is answered
// by a binary search of k halving steps (k = ceil(log2(n+1)), 11 at 1024 cues),
// by a local walk stepping one cue at a time from the last index found, or with no
// hit on an empty table; each step costs one table read plus one compare. The next
// word is taken once the result is registered; while out_stall holds, the result waits.
// Reset clears history and config to defaults; the cue table is not cleared.
`default_nettype none

module timed_cue_lookup #(
  parameter int MAX_CUES = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      op,
  input  wire logic [9:0]                slot,
  input  wire logic [31:0]               cue_start,
  input  wire logic [31:0]               cue_end,
  input  wire logic [31:0]               position,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           hit,
  output tcl_pkg::cue_idx_t              found_index,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tcl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready
);

  import tcl_pkg::*;

  localparam int IW = $clog2(MAX_CUES);
  localparam int NW = IW + 1;
  localparam int CW = (NW > 11) ? NW : 11;
  localparam logic [16:0] MAX_L = 17'(MAX_CUES);

  // configuration
  logic [10:0] cue_count;
  logic [15:0] back_window;
  logic [15:0] forward_window;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cue_count      <= CUE_COUNT_RST;
      back_window    <= BACK_WINDOW_RST;
      forward_window <= FWD_WINDOW_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_CUE_COUNT:   cue_count      <= pwdata[10:0];
        REG_BACK_WINDOW: back_window    <= pwdata[15:0];
        REG_FWD_WINDOW:  forward_window <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CUE_COUNT:   prdata = {21'd0, cue_count};
      REG_BACK_WINDOW: prdata = {16'd0, back_window};
      REG_FWD_WINDOW:  prdata = {16'd0, forward_window};
      default:         prdata = 32'd0;
    endcase
  end

  // active cue count, clamped to the table size
  logic [CW-1:0] cnt_ext;
  logic [NW-1:0] n;
  assign cnt_ext = CW'(cue_count);
  assign n = (cnt_ext > CW'(MAX_CUES)) ? NW'(MAX_CUES) : NW'(cnt_ext);

  // controller state and datapath
  tcl_state_t    state, state_next;
  logic [31:0]   pos;
  logic          pos_load;
  logic [NW-1:0] lo, lo_next, hi, hi_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW-1:0] kept_index;
  logic [31:0]   last_position;
  logic          history_valid;
  logic          hist_clear, hist_upd;
  logic          out_load, out_hit_d;
  cue_idx_t      out_idx_d;

  logic          wr_en, rd_en;
  logic [IW-1:0] rd_addr;
  logic [31:0]   rd_start, rd_end;

  logic [NW:0]   sum;
  logic [IW-1:0] mid;
  logic [IW-1:0] hint;
  logic          back_far, fwd_far, do_search;
  logic          hit_now, out_free;

  assign sum  = {1'b0, lo} + {1'b0, hi};
  assign mid  = IW'(sum >> 1);
  assign hint = ({1'b0, kept_index} >= n) ? IW'(n - 1'b1) : kept_index;

  assign back_far  = (last_position >= 32'(back_window)) &&
                     (pos < last_position - 32'(back_window));
  assign fwd_far   = (33'(pos) > 33'(last_position) + 33'(forward_window));
  assign do_search = !history_valid || back_far || fwd_far;

  assign hit_now  = (rd_start <= pos) && (pos <= rd_end);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  tcl_cue_mem #(
    .DEPTH (MAX_CUES)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (IW'(slot)),
    .wr_start (cue_start),
    .wr_end   (cue_end),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_start (rd_start),
    .rd_end   (rd_end)
  );

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    cur_next   = cur;
    pos_load   = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cur;
    hist_clear = 1'b0;
    hist_upd   = 1'b0;
    out_load   = 1'b0;
    out_hit_d  = 1'b0;
    out_idx_d  = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op == OP_LOAD) begin
            wr_en      = (17'(slot) < MAX_L);
            hist_clear = 1'b1;
          end else begin
            pos_load   = 1'b1;
            state_next = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (n == '0) begin
          state_next = ST_EMPTY;
        end else if (do_search) begin
          lo_next    = '0;
          hi_next    = n;
          state_next = ST_SRCH_RD;
        end else begin
          cur_next   = hint;
          state_next = ST_WALK_RD_DN;
        end
      end
      ST_EMPTY: begin
        // empty table: no hit, history untouched
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SRCH_RD: begin
        if (lo < hi) begin
          rd_en      = 1'b1;
          rd_addr    = mid;
          state_next = ST_SRCH_CMP;
        end else begin
          cur_next   = (lo == '0) ? '0 : IW'(lo - 1'b1);
          state_next = ST_FIN_RD;
        end
      end
      ST_SRCH_CMP: begin
        if (rd_start <= pos) begin
          lo_next = NW'(mid) + 1'b1;
        end else begin
          hi_next = NW'(mid);
        end
        state_next = ST_SRCH_RD;
      end
      ST_FIN_RD: begin
        rd_en      = 1'b1;
        state_next = ST_FIN_CHK;
      end
      ST_FIN_CHK: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_hit_d  = hit_now;
          out_idx_d  = cue_idx_t'(cur);
          hist_upd   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WALK_RD_DN: begin
        rd_en      = 1'b1;
        state_next = ST_WALK_DN;
      end
      ST_WALK_DN: begin
        if ((cur != '0) && (pos < rd_start)) begin
          cur_next   = cur - 1'b1;
          state_next = ST_WALK_RD_DN;
        end else begin
          state_next = ST_WALK_UP;
        end
      end
      ST_WALK_RD_UP: begin
        rd_en      = 1'b1;
        state_next = ST_WALK_UP;
      end
      ST_WALK_UP: begin
        // read data still belongs to cur, so the exit goes straight to the check
        if ((NW'(cur) + 1'b1 < n) && (pos > rd_end)) begin
          cur_next   = cur + 1'b1;
          state_next = ST_WALK_RD_UP;
        end else begin
          state_next = ST_FIN_CHK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      history_valid <= 1'b0;
      kept_index    <= '0;
      last_position <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (hist_clear) begin
        history_valid <= 1'b0;
      end else if (hist_upd) begin
        history_valid <= 1'b1;
        kept_index    <= cur;
        last_position <= pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    cur <= cur_next;
    if (pos_load) begin
      pos <= position;
    end
    if (out_load) begin
      hit         <= out_hit_d;
      found_index <= out_idx_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tcl_cue_mem.sv */
// Cue table: start and end stores, one write port and one read port
// with separate addresses, read data registered. No package dependencies.
`default_nettype none

module tcl_cue_mem #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [31:0]              wr_start,
  input  wire logic [31:0]              wr_end,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [31:0]              rd_start,
  output logic      [31:0]              rd_end
);

  logic [31:0] start_mem [DEPTH];
  logic [31:0] end_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr] <= wr_start;
      end_mem[wr_addr]   <= wr_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start <= start_mem[rd_addr];
      rd_end   <= end_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
